[sv/bpq_pkg.sv]
// Shared types and field widths of the buffer pool queue manager.
package bpq_pkg;

    localparam int COMMAND_W    = 3;
    localparam int HANDLE_W     = 4;
    localparam int SLOT_W       = 4;
    localparam int ITEM_COUNT_W = 5;
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 8;

    localparam logic [ITEM_COUNT_W-1:0] ITEM_COUNT_RST = 5'd16;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_INIT    = 3'd0,
        CMD_ALLOC   = 3'd1,
        CMD_COMMIT  = 3'd2,
        CMD_TAKE    = 3'd3,
        CMD_RELEASE = 3'd4,
        CMD_FLUSH   = 3'd5
    } cmd_t;

    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
    } bpq_mem_ctl_t;

endpackage

[sv/buffer_pool_queue_manager.sv]
// Buffer pool queue manager: free list and commit queue over one link memory.
//
// One command is in work at a time; the next transfer is taken while the last
// result still waits on the output. Allocate, take, release, commit onto an
// empty queue and unknown codes finish in ST_EXEC; commit onto a non-empty queue
// adds a tail write in ST_COMMIT_TAIL, init writes a link per slot in ST_INIT_WALK,
// and flush moves slots via ST_FLUSH_WR and ST_FLUSH_RD. This follows from the
// link memory: one write port and one read port with registered read data, so
// each flush step is a read followed by a write. The link memory is not cleared
// at reset and needs no clearing pass; run init before allocating.
module buffer_pool_queue_manager #(
    parameter int POOL_SLOTS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // cfg_data: item_count
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bpq_pkg::ITEM_COUNT_W-1:0]      cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata: [2:0] command, [6:3] handle, [7] zero
    input  logic [bpq_pkg::IN_DATA_W-1:0]         s_tdata,
    // s_tuser: handle_valid
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: [3:0] slot, [7:4] zero
    output logic [bpq_pkg::OUT_DATA_W-1:0]        m_tdata,
    // m_tuser: found
    output logic                                  m_tuser
);
    import bpq_pkg::*;

    localparam int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int LW = $clog2(POOL_SLOTS + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_INIT_WALK,
        ST_COMMIT_TAIL,
        ST_FLUSH_RD,
        ST_FLUSH_WR,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [ITEM_COUNT_W-1:0] item_count_reg, item_count_next;
    logic [LW-1:0]           free_top_reg, free_top_next;
    logic [LW-1:0]           queue_first_reg, queue_first_next;
    logic [IW-1:0]           queue_last_reg, queue_last_next;

    cmd_t                    cmd_reg, cmd_next;
    logic                    hv_reg, hv_next;
    logic [IW-1:0]           h_reg, h_next;
    logic [IW-1:0]           cnt_reg, cnt_next;
    logic [IW-1:0]           last_reg, last_next;
    logic [LW-1:0]           fcnt_reg, fcnt_next;
    logic [SLOT_W-1:0]       res_slot_reg, res_slot_next;
    logic                    res_found_reg, res_found_next;
    logic [SLOT_W-1:0]       out_slot_reg, out_slot_next;
    logic                    out_found_reg, out_found_next;

    bpq_mem_ctl_t            mem_ctl;
    logic [IW-1:0]           wr_addr;
    logic [LW-1:0]           wr_data;
    logic [IW-1:0]           rd_addr;
    logic [LW-1:0]           rd_data;

    logic                    in_xfer;
    logic                    out_free;
    logic                    fin;
    logic [SLOT_W-1:0]       fin_slot;
    logic                    fin_found;
    cmd_t                    in_cmd;
    logic [HANDLE_W-1:0]     in_handle;
    logic [31:0]             count_sat;
    logic [LW+SLOT_W-1:0]    slot_wide;

    bpq_link_mem #(
        .DEPTH (POOL_SLOTS),
        .AW    (IW),
        .DW    (LW)
    ) u_link_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_cmd    = cmd_t'(s_tdata[COMMAND_W-1:0]);
    assign in_handle = s_tdata[COMMAND_W+HANDLE_W-1:COMMAND_W];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-SLOT_W){1'b0}}, out_slot_reg};
    assign m_tuser  = out_found_reg;

    always_comb
    begin
        state_next       = state_reg;
        item_count_next  = item_count_reg;
        free_top_next    = free_top_reg;
        queue_first_next = queue_first_reg;
        queue_last_next  = queue_last_reg;
        cmd_next         = cmd_reg;
        hv_next          = hv_reg;
        h_next           = h_reg;
        cnt_next         = cnt_reg;
        last_next        = last_reg;
        fcnt_next        = fcnt_reg;
        mem_ctl          = '0;
        wr_addr          = '0;
        wr_data          = NULL_LINK;
        rd_addr          = '0;
        fin              = 1'b0;
        fin_slot         = '0;
        fin_found        = 1'b0;
        count_sat        = 32'(item_count_reg);
        slot_wide        = '0;

        if (cfg_valid && cfg_ready)
        begin
            item_count_next = cfg_data;
        end
        if (count_sat > 32'(POOL_SLOTS))
        begin
            count_sat = 32'(POOL_SLOTS);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next   = in_cmd;
                    h_next     = IW'(in_handle);
                    hv_next    = s_tuser && (32'(in_handle) < 32'(POOL_SLOTS));
                    state_next = ST_EXEC;
                    // prefetch the link behind the list head the command pops
                    if (in_cmd == CMD_ALLOC)
                    begin
                        rd_addr        = IW'(free_top_reg);
                        mem_ctl.rd_en  = (free_top_reg != NULL_LINK);
                    end
                    else
                    begin
                        rd_addr        = IW'(queue_first_reg);
                        mem_ctl.rd_en  = (queue_first_reg != NULL_LINK);
                    end
                end
            end
            ST_EXEC:
            begin
                case (cmd_reg)
                    CMD_INIT:
                    begin
                        queue_first_next = NULL_LINK;
                        queue_last_next  = '0;
                        cnt_next         = '0;
                        if (count_sat == 32'd0)
                        begin
                            free_top_next = NULL_LINK;
                            fin           = 1'b1;
                        end
                        else
                        begin
                            free_top_next = LW'(count_sat - 32'd1);
                            last_next     = IW'(count_sat - 32'd1);
                            state_next    = ST_INIT_WALK;
                        end
                    end
                    CMD_ALLOC:
                    begin
                        fin = 1'b1;
                        if (free_top_reg != NULL_LINK)
                        begin
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = IW'(free_top_reg);
                            wr_data       = NULL_LINK;
                            free_top_next = rd_data;
                            slot_wide     = (LW+SLOT_W)'(free_top_reg);
                            fin_slot      = slot_wide[SLOT_W-1:0];
                            fin_found     = 1'b1;
                        end
                    end
                    CMD_COMMIT:
                    begin
                        if (hv_reg)
                        begin
                            mem_ctl.wr_en   = 1'b1;
                            wr_addr         = h_reg;
                            wr_data         = NULL_LINK;
                            queue_last_next = h_reg;
                            if (queue_first_reg != NULL_LINK)
                            begin
                                // hold queue_last until the tail link is written
                                queue_last_next = queue_last_reg;
                                state_next      = ST_COMMIT_TAIL;
                            end
                            else
                            begin
                                queue_first_next = LW'(h_reg);
                                fin              = 1'b1;
                            end
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    CMD_TAKE:
                    begin
                        fin = 1'b1;
                        if (queue_first_reg != NULL_LINK)
                        begin
                            queue_first_next = rd_data;
                            slot_wide        = (LW+SLOT_W)'(queue_first_reg);
                            fin_slot         = slot_wide[SLOT_W-1:0];
                            fin_found        = 1'b1;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        fin = 1'b1;
                        if (hv_reg)
                        begin
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = h_reg;
                            wr_data       = free_top_reg;
                            free_top_next = LW'(h_reg);
                        end
                    end
                    CMD_FLUSH:
                    begin
                        fcnt_next  = '0;
                        state_next = ST_FLUSH_WR;
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            ST_INIT_WALK:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = cnt_reg;
                wr_data       = (cnt_reg == '0) ? NULL_LINK : (LW'(cnt_reg) - LW'(1));
                cnt_next      = cnt_reg + IW'(1);
                if (cnt_reg == last_reg)
                begin
                    fin = 1'b1;
                end
            end
            ST_COMMIT_TAIL:
            begin
                mem_ctl.wr_en   = 1'b1;
                wr_addr         = queue_last_reg;
                wr_data         = LW'(h_reg);
                queue_last_next = h_reg;
                fin             = 1'b1;
            end
            ST_FLUSH_RD:
            begin
                rd_addr       = IW'(queue_first_reg);
                mem_ctl.rd_en = (queue_first_reg != NULL_LINK);
                state_next    = ST_FLUSH_WR;
            end
            ST_FLUSH_WR:
            begin
                // move the queue head onto the free list, bounded by the pool size
                if ((queue_first_reg != NULL_LINK) && (fcnt_reg != NULL_LINK))
                begin
                    mem_ctl.wr_en    = 1'b1;
                    wr_addr          = IW'(queue_first_reg);
                    wr_data          = free_top_reg;
                    free_top_next    = queue_first_reg;
                    queue_first_next = rd_data;
                    fcnt_next        = fcnt_reg + LW'(1);
                    state_next       = ST_FLUSH_RD;
                end
                else
                begin
                    queue_first_next = NULL_LINK;
                    fin              = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = out_free ? ST_IDLE : ST_DONE;
        end
    end

    // result path: finished command goes straight out when the output is free
    always_comb
    begin
        res_slot_next  = res_slot_reg;
        res_found_next = res_found_reg;
        out_slot_next  = out_slot_reg;
        out_found_next = out_found_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        if (fin)
        begin
            res_slot_next  = fin_slot;
            res_found_next = fin_found;
            if (out_free)
            begin
                out_slot_next  = fin_slot;
                out_found_next = fin_found;
                m_tvalid_next  = 1'b1;
            end
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            out_slot_next  = res_slot_reg;
            out_found_next = res_found_reg;
            m_tvalid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            item_count_reg  <= ITEM_COUNT_RST;
            free_top_reg    <= NULL_LINK;
            queue_first_reg <= NULL_LINK;
            queue_last_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            m_tvalid_reg    <= m_tvalid_next;
            item_count_reg  <= item_count_next;
            free_top_reg    <= free_top_next;
            queue_first_reg <= queue_first_next;
            queue_last_reg  <= queue_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        hv_reg        <= hv_next;
        h_reg         <= h_next;
        cnt_reg       <= cnt_next;
        last_reg      <= last_next;
        fcnt_reg      <= fcnt_next;
        res_slot_reg  <= res_slot_next;
        res_found_reg <= res_found_next;
        out_slot_reg  <= out_slot_next;
        out_found_reg <= out_found_next;
    end

endmodule

[sv/bpq_link_mem.sv]
// Single-port-write, single-port-read link memory with registered read data.
module bpq_link_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 5
) (
    input  logic                     clk,
    input  bpq_pkg::bpq_mem_ctl_t    ctl,
    input  logic [AW-1:0]            wr_addr,
    input  logic [DW-1:0]            wr_data,
    input  logic [AW-1:0]            rd_addr,
    output logic [DW-1:0]            rd_data
);
    import bpq_pkg::*;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
